@@ rtl/core/spre_pkg.sv @@
package spre_pkg;

    localparam int MAX_ANGLE   = 90;
    localparam int RATE_LEVELS = 8;
    localparam int TAB_TO_STEPS = 23;

    localparam int ANG_W  = 7;
    localparam int TAB_W  = 10;
    localparam int Q8_W   = 15;
    localparam int PH_W   = 2;
    localparam int LVL_W  = 3;
    localparam int RATE_W = 11;
    localparam int STEP_W = 15;
    localparam int TIME_W = 24;
    localparam int EL_W   = 25;
    localparam int PROD_W = 26;
    localparam int DEN_W  = 16;

    // pipelined divider widths, used by both dividers; the fraction divisor reaches 14 * 23 * 1666
    localparam int DIV_NW = 28;
    localparam int DIV_DW = 20;
    localparam int DIV_QW = 10;

    // configuration port
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 24;

    localparam logic [CFG_AW-1:0] REG_SETUP_UP    = 3'd0;
    localparam logic [CFG_AW-1:0] REG_SETUP_DOWN  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_SETTLE_UP   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_SETTLE_DOWN = 3'd3;
    localparam logic [CFG_AW-1:0] REG_CALIB       = 3'd4;

    localparam logic [PH_W-1:0] PH_ARRIVED = 2'd0;
    localparam logic [PH_W-1:0] PH_SETUP   = 2'd1;
    localparam logic [PH_W-1:0] PH_MOVING  = 2'd2;
    localparam logic [PH_W-1:0] PH_UNKNOWN = 2'd3;

    localparam logic [Q8_W-1:0]  FULL_Q8 = 15'd23040;
    localparam logic [TAB_W-1:0] TAB_END = 10'd907;

    // ramp time of the full span (11578582 us) and full span at top rate (9637782 us)
    localparam logic [TIME_W-1:0] LIM_KNOWN_BASE = 24'd11578582;
    localparam logic [TIME_W-1:0] LIM_UNK_BASE   = 24'd9637782;

    // per-step time of each rate level, us
    localparam logic [RATE_W-1:0] RATE_US [RATE_LEVELS] =
        '{11'd1666, 11'd1348, 11'd1029, 11'd709, 11'd629, 11'd549, 11'd509, 11'd462};
    // steps taken before level k while accelerating
    localparam logic [RATE_W-1:0] LSUM [RATE_LEVELS] =
        '{11'd0, 11'd400, 11'd700, 11'd900, 11'd1100, 11'd1300, 11'd1500, 11'd1700};
    // time spent before level k while accelerating, us
    localparam logic [20:0] ASUM [RATE_LEVELS] =
        '{21'd0, 21'd666400, 21'd1070800, 21'd1276600,
          21'd1418400, 21'd1544200, 21'd1654000, 21'd1755800};

    localparam logic [TAB_W-1:0] ANG_TAB [MAX_ANGLE+1] = '{
        10'd0,   10'd7,   10'd14,  10'd21,  10'd28,  10'd35,  10'd42,  10'd49,  10'd56,  10'd64,
        10'd71,  10'd78,  10'd86,  10'd93,  10'd101, 10'd109, 10'd116, 10'd125, 10'd134, 10'd141,
        10'd150, 10'd156, 10'd165, 10'd174, 10'd183, 10'd192, 10'd201, 10'd210, 10'd218, 10'd229,
        10'd239, 10'd248, 10'd254, 10'd267, 10'd277, 10'd287, 10'd296, 10'd306, 10'd316, 10'd326,
        10'd336, 10'd344, 10'd356, 10'd367, 10'd377, 10'd388, 10'd398, 10'd409, 10'd417, 10'd431,
        10'd440, 10'd453, 10'd463, 10'd474, 10'd487, 10'd498, 10'd509, 10'd519, 10'd531, 10'd541,
        10'd554, 10'd565, 10'd576, 10'd588, 10'd599, 10'd612, 10'd622, 10'd635, 10'd647, 10'd658,
        10'd670, 10'd681, 10'd694, 10'd706, 10'd719, 10'd730, 10'd743, 10'd754, 10'd766, 10'd779,
        10'd791, 10'd801, 10'd812, 10'd825, 10'd838, 10'd850, 10'd860, 10'd873, 10'd884, 10'd896,
        10'd907
    };

    typedef struct packed {
        logic [19:0] setup_up_us;
        logic [19:0] setup_down_us;
        logic [19:0] settle_up_us;
        logic [19:0] settle_down_us;
        logic [23:0] calib_latency_us;
    } spre_cfg_t;

    typedef struct packed {
        logic             start_known;
        logic [ANG_W-1:0] start_angle;
        logic             dest_known;
        logic [ANG_W-1:0] dest_angle;
        logic [31:0]      elapsed_us;
    } spre_in_t;

    typedef struct packed {
        logic            known;
        logic [Q8_W-1:0] q8;
        logic [PH_W-1:0] phase;
    } spre_res_t;

    // sideband that rides along the divider stages
    typedef struct packed {
        spre_res_t        res;
        logic             moving;
        logic [DEN_W-1:0] den;
        logic [ANG_W-1:0] idx;
        logic             full;
    } spre_side_t;

    function automatic logic [TAB_W-1:0] tab_lookup(input logic [ANG_W-1:0] idx);
        logic [TAB_W-1:0] v;
        v = '0;
        if (idx <= ANG_W'(MAX_ANGLE))
        begin
            v = ANG_TAB[idx];
        end
        return v;
    endfunction

endpackage

@@ rtl/core/spre_div.sv @@
module spre_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [spre_pkg::DIV_NW-1:0] dvd,
    input  logic [spre_pkg::DIV_DW-1:0] dsr,
    input  spre_pkg::spre_side_t        in_side,
    output logic                        out_valid,
    output logic [spre_pkg::DIV_QW-1:0] quo,
    output logic [spre_pkg::DIV_NW-1:0] rem,
    output spre_pkg::spre_side_t        out_side
);
    import spre_pkg::*;

    localparam int TW = DIV_DW + DIV_QW;

    // one quotient bit per stage, MSB first
    logic              v_reg    [DIV_QW];
    logic [DIV_NW-1:0] rem_reg  [DIV_QW];
    logic [DIV_QW-1:0] quo_reg  [DIV_QW];
    logic [DIV_DW-1:0] dsr_reg  [DIV_QW];
    spre_side_t        side_reg [DIV_QW];

    for (genvar k = 0; k < DIV_QW; k++)
    begin : g_stage
        logic              v_src;
        logic [DIV_NW-1:0] rem_src;
        logic [DIV_QW-1:0] quo_src;
        logic [DIV_DW-1:0] dsr_src;
        spre_side_t        side_src;
        logic [TW-1:0]     trial;
        logic              fits;

        if (k == 0)
        begin : g_head
            assign v_src    = in_valid;
            assign rem_src  = dvd;
            assign quo_src  = '0;
            assign dsr_src  = dsr;
            assign side_src = in_side;
        end
        else
        begin : g_body
            assign v_src    = v_reg[k-1];
            assign rem_src  = rem_reg[k-1];
            assign quo_src  = quo_reg[k-1];
            assign dsr_src  = dsr_reg[k-1];
            assign side_src = side_reg[k-1];
        end

        assign trial = TW'(dsr_src) << (DIV_QW - 1 - k);
        assign fits  = TW'(rem_src) >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= fits ? (rem_src - DIV_NW'(trial)) : rem_src;
                quo_reg[k]  <= {quo_src[DIV_QW-2:0], fits};
                dsr_reg[k]  <= dsr_src;
                side_reg[k] <= side_src;
            end
        end
    end

    assign out_valid = v_reg[DIV_QW-1];
    assign quo       = quo_reg[DIV_QW-1];
    assign rem       = rem_reg[DIV_QW-1];
    assign out_side  = side_reg[DIV_QW-1];

    // quotient must fit: the remainder ends below the divisor
    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[DIV_QW-1] && side_reg[DIV_QW-1].moving
        |-> rem_reg[DIV_QW-1] < DIV_NW'(dsr_reg[DIV_QW-1]))
        else $error("divider remainder not below divisor");

endmodule

@@ rtl/core/spre_ramp.sv @@
module spre_ramp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  spre_pkg::spre_in_t          in_beat,
    input  spre_pkg::spre_cfg_t         cfg,
    output logic                        out_valid,
    output logic [spre_pkg::DIV_NW-1:0] q,
    output spre_pkg::spre_side_t        side
);
    import spre_pkg::*;

    typedef enum logic [1:0] {RG_ASC, RG_TOP, RG_DESC} region_t;

    typedef struct packed {
        logic              early;
        spre_res_t         res;
        logic [ANG_W-1:0]  s;
        logic [ANG_W-1:0]  d;
        logic              up;
        logic [EL_W-1:0]   el;
        logic [19:0]       setup;
        logic [STEP_W-1:0] total;
        logic [STEP_W-1:0] tab_s23;
        logic [LVL_W-1:0]  top;
        logic [LVL_W-1:0]  j;
        logic [STEP_W-1:0] n;
        logic [TIME_W-1:0] ntime;
        logic [TIME_W-1:0] t;
        region_t           region;
        logic [TIME_W-1:0] xz;
        logic [STEP_W-1:0] coef;
        logic [TIME_W-1:0] off;
        logic [RATE_W-1:0] rate;
        logic [PROD_W-1:0] prod1;
        logic [PROD_W-1:0] prod2;
        logic [DEN_W-1:0]  den;
        logic [PROD_W-1:0] q;
    } rs_t;

    localparam int NST = 7;

    logic [NST-1:0] v_reg;
    rs_t s1_reg, s2_reg, s3_reg, s4_reg, s5_reg, s6_reg, s7_reg;
    rs_t s1_next, s2_next, s3_next, s4_next, s5_next, s6_next, s7_next;

    // stage 1 temporaries
    logic             sk, dk;
    logic [TAB_W-1:0] tab_s, tab_d, absd;
    logic [EL_W-1:0]  lim;
    logic             past;
    // stage 2..7 temporaries
    logic [LVL_W-1:0]  top_cnt, lt_cnt, le_cnt, j, j1;
    logic [EL_W-1:0]   transit;
    logic [EL_W:0]     t_end;
    logic [TIME_W-1:0] a_top;
    logic [EL_W:0]     z_full;
    logic [PROD_W:0]   m_full, q_full;

    // stage 1: range check, time limits, step count of the move
    always_comb
    begin
        sk    = in_beat.start_known && (in_beat.start_angle <= ANG_W'(MAX_ANGLE));
        dk    = in_beat.dest_known && (in_beat.dest_angle <= ANG_W'(MAX_ANGLE));
        tab_s = tab_lookup(in_beat.start_angle);
        tab_d = tab_lookup(in_beat.dest_angle);
        lim   = sk ? (EL_W'(LIM_KNOWN_BASE) + EL_W'(cfg.setup_down_us) + EL_W'(cfg.settle_down_us))
                   : (EL_W'(LIM_UNK_BASE) + EL_W'(cfg.calib_latency_us));
        past  = $signed(in_beat.elapsed_us) >= $signed({7'b0, lim});
        s1_next       = '0;
        s1_next.s     = in_beat.start_angle;
        s1_next.d     = in_beat.dest_angle;
        s1_next.up    = in_beat.dest_angle > in_beat.start_angle;
        absd          = s1_next.up ? (tab_d - tab_s) : (tab_s - tab_d);
        s1_next.total   = STEP_W'(absd) * STEP_W'(TAB_TO_STEPS);
        s1_next.tab_s23 = STEP_W'(tab_s) * STEP_W'(TAB_TO_STEPS);
        s1_next.setup   = s1_next.up ? cfg.setup_up_us : cfg.setup_down_us;
        s1_next.el      = in_beat.elapsed_us[EL_W-1:0];
        s1_next.early   = 1'b1;
        s1_next.res     = '{known: 1'b0, q8: '0, phase: PH_UNKNOWN};
        if (past)
        begin
            if (dk)
            begin
                s1_next.res = '{known: 1'b1, q8: {in_beat.dest_angle, 8'b0}, phase: PH_ARRIVED};
            end
        end
        else if (sk && dk && !in_beat.elapsed_us[31])
        begin
            s1_next.early = 1'b0;
        end
    end

    // stage 2: top rate level reached and time spent at it
    always_comb
    begin
        s2_next = s1_reg;
        top_cnt = '0;
        for (int k = 1; k < RATE_LEVELS; k++)
        begin
            if (s1_reg.total >= STEP_W'({LSUM[k], 1'b0}))
            begin
                top_cnt = top_cnt + LVL_W'(1);
            end
        end
        s2_next.top   = top_cnt;
        s2_next.n     = s1_reg.total - STEP_W'({LSUM[top_cnt], 1'b0});
        s2_next.ntime = TIME_W'(s2_next.n) * TIME_W'(RATE_US[top_cnt]);
    end

    // stage 3: setup delay / arrived / moving
    always_comb
    begin
        s3_next = s2_reg;
        transit = EL_W'({ASUM[s2_reg.top], 1'b0}) + EL_W'(s2_reg.ntime);
        t_end   = (EL_W+1)'(transit) + (EL_W+1)'(s2_reg.setup);
        s3_next.t = TIME_W'(s2_reg.el - EL_W'(s2_reg.setup));
        if (!s2_reg.early)
        begin
            if ((EL_W+1)'(s2_reg.el) >= t_end)
            begin
                s3_next.early = 1'b1;
                s3_next.res   = '{known: 1'b1, q8: {s2_reg.d, 8'b0}, phase: PH_ARRIVED};
            end
            else if (s2_reg.el <= EL_W'(s2_reg.setup))
            begin
                s3_next.early = 1'b1;
                s3_next.res   = '{known: 1'b1, q8: {s2_reg.s, 8'b0}, phase: PH_SETUP};
            end
        end
    end

    // stage 4: ramp region; the descending side is mirrored onto the ascending one
    always_comb
    begin
        s4_next = s3_reg;
        a_top   = TIME_W'(ASUM[s3_reg.top]);
        z_full  = (EL_W+1)'({a_top, 1'b0}) + (EL_W+1)'(s3_reg.ntime) - (EL_W+1)'(s3_reg.t);
        if (s3_reg.t <= a_top)
        begin
            s4_next.region = RG_ASC;
            s4_next.xz     = s3_reg.t;
        end
        else if (EL_W'(s3_reg.t) <= EL_W'(a_top) + EL_W'(s3_reg.ntime))
        begin
            s4_next.region = RG_TOP;
            s4_next.xz     = s3_reg.t;
        end
        else
        begin
            s4_next.region = RG_DESC;
            s4_next.xz     = TIME_W'(z_full);
        end
    end

    // stage 5: level in use, steps already done and time into it
    always_comb
    begin
        s5_next = s4_reg;
        lt_cnt  = '0;
        le_cnt  = '0;
        for (int k = 1; k < RATE_LEVELS; k++)
        begin
            if (TIME_W'(ASUM[k]) < s4_reg.xz)
            begin
                lt_cnt = lt_cnt + LVL_W'(1);
            end
            if (TIME_W'(ASUM[k]) <= s4_reg.xz)
            begin
                le_cnt = le_cnt + LVL_W'(1);
            end
        end
        j  = s4_reg.top;
        j1 = le_cnt + LVL_W'(1);
        s5_next.coef = STEP_W'(LSUM[s4_reg.top]);
        s5_next.off  = s4_reg.xz - TIME_W'(ASUM[s4_reg.top]);
        case (s4_reg.region)
            RG_ASC:
            begin
                j            = lt_cnt;
                s5_next.coef = STEP_W'(LSUM[lt_cnt]);
                s5_next.off  = s4_reg.xz - TIME_W'(ASUM[lt_cnt]);
            end
            RG_DESC:
            begin
                j            = le_cnt;
                s5_next.coef = STEP_W'({LSUM[s4_reg.top], 1'b0}) + s4_reg.n
                               - STEP_W'(LSUM[j1]);
                s5_next.off  = TIME_W'(ASUM[j1]) - s4_reg.xz;
            end
            default:
            begin
                j = s4_reg.top;
            end
        endcase
        s5_next.j    = j;
        s5_next.rate = RATE_US[j];
    end

    // stage 6: products on the selected rate
    always_comb
    begin
        s6_next       = s5_reg;
        s6_next.prod1 = PROD_W'(s5_reg.coef) * PROD_W'(s5_reg.rate);
        s6_next.prod2 = PROD_W'(s5_reg.tab_s23) * PROD_W'(s5_reg.rate);
        s6_next.den   = DEN_W'(s5_reg.rate) * DEN_W'(TAB_TO_STEPS);
    end

    // stage 7: table position scaled by den
    always_comb
    begin
        s7_next = s6_reg;
        m_full  = (PROD_W+1)'(s6_reg.prod1) + (PROD_W+1)'(s6_reg.off);
        q_full  = s6_reg.up ? ((PROD_W+1)'(s6_reg.prod2) + m_full)
                            : ((PROD_W+1)'(s6_reg.prod2) - m_full);
        s7_next.q = PROD_W'(q_full);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NST-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
            s6_reg <= s6_next;
            s7_reg <= s7_next;
        end
    end

    assign out_valid   = v_reg[NST-1];
    assign q           = DIV_NW'(s7_reg.q);
    assign side.res    = s7_reg.res;
    assign side.moving = !s7_reg.early;
    assign side.den    = s7_reg.den;
    assign side.idx    = '0;
    assign side.full   = 1'b0;

endmodule

@@ rtl/core/spre_interp.sv @@
module spre_interp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [spre_pkg::DIV_QW-1:0] quo,
    input  logic [spre_pkg::DIV_NW-1:0] rem,
    input  spre_pkg::spre_side_t        in_side,
    output logic                        out_valid,
    output logic [spre_pkg::DIV_NW-1:0] num,
    output logic [spre_pkg::DIV_DW-1:0] gap,
    output spre_pkg::spre_side_t        out_side
);
    import spre_pkg::*;

    logic             v1_reg, v2_reg;
    logic [TAB_W-1:0] f1_reg;
    logic [DEN_W-1:0] r1_reg;
    spre_side_t       side1_reg, side2_reg, side1_next;
    logic [DIV_NW-1:0] num_reg, num_next;
    logic [DIV_DW-1:0] gap_reg, gap_next;

    logic [ANG_W-1:0]  cnt;
    logic [TAB_W-1:0]  lo, hi;
    logic [3:0]        g, fd;
    logic [DIV_DW-1:0] part;

    // whole table segment holding the integer position
    always_comb
    begin
        cnt = '0;
        for (int k = 1; k < MAX_ANGLE; k++)
        begin
            if (ANG_TAB[k] <= quo)
            begin
                cnt = cnt + ANG_W'(1);
            end
        end
        side1_next      = in_side;
        side1_next.idx  = cnt;
        side1_next.full = quo >= TAB_END;
    end

    // fraction inside the segment, to be divided by the segment length
    always_comb
    begin
        lo       = ANG_TAB[side1_reg.idx];
        hi       = ANG_TAB[side1_reg.idx + ANG_W'(1)];
        g        = 4'(hi - lo);
        fd       = 4'(f1_reg - lo);
        part     = DIV_DW'(fd) * DIV_DW'(side1_reg.den) + DIV_DW'(r1_reg);
        num_next = DIV_NW'({part, 8'b0});
        gap_next = DIV_DW'(g) * DIV_DW'(side1_reg.den);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_reg    <= quo;
            r1_reg    <= rem[DEN_W-1:0];
            side1_reg <= side1_next;
            num_reg   <= num_next;
            gap_reg   <= gap_next;
            side2_reg <= side1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign num       = num_reg;
    assign gap       = gap_reg;
    assign out_side  = side2_reg;

endmodule

@@ rtl/core/stepper_ramp_position_estimator.sv @@
// Stepper tilt position estimator. Each input beat carries a start angle, a
// target angle (whole degrees with known flags) and the signed time since the
// move command; each beat yields exactly one result beat with the estimated
// angle in Q8 degrees and a phase code (arrived, setup delay, moving, unknown).
// The datapath is a fully pipelined chain: seven ramp stages (time limits,
// top rate level, region of the ramp, products), a ten-stage restoring
// divider that gives the table position, two interpolation stages, a second
// ten-stage divider for the fraction within the table segment, and an output
// register. A new beat is taken every cycle unless the chain is stalled; the
// shared stall signal comes from the output register's state and m_tready,
// so backpressure on the result side freezes the whole chain. Config
// registers are written through cfg_we/cfg_addr/cfg_wdata and should only
// change while no beat is in flight.
module stepper_ramp_position_estimator (
    input  logic                        clk,
    input  logic                        rst_n,
    // tdata: start_known[0], start_angle[7:1], dest_known[8],
    //        dest_angle[15:9], elapsed_us[47:16]
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [47:0]                 s_tdata,
    // tdata: angle_known[0], angle_q8[15:1], phase[17:16], zero pad [23:18]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [23:0]                 m_tdata,
    input  logic                        cfg_we,
    input  logic [spre_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [spre_pkg::CFG_DW-1:0] cfg_wdata
);
    import spre_pkg::*;

    spre_cfg_t cfg_reg;
    spre_in_t  in_beat;
    logic      adv;

    logic              r_valid;
    logic [DIV_NW-1:0] r_q;
    spre_side_t        r_side;

    logic              d1_valid;
    logic [DIV_QW-1:0] d1_quo;
    logic [DIV_NW-1:0] d1_rem;
    spre_side_t        d1_side;

    logic              i_valid;
    logic [DIV_NW-1:0] i_num;
    logic [DIV_DW-1:0] i_gap;
    spre_side_t        i_side;

    logic              d2_valid;
    logic [DIV_QW-1:0] d2_quo;
    logic [DIV_NW-1:0] d2_rem;
    spre_side_t        d2_side;

    logic              out_valid_reg;
    spre_res_t         out_reg, out_next;

    // the whole chain moves whenever the output slot is free or being drained
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    assign in_beat.start_known = s_tdata[0];
    assign in_beat.start_angle = s_tdata[7:1];
    assign in_beat.dest_known  = s_tdata[8];
    assign in_beat.dest_angle  = s_tdata[15:9];
    assign in_beat.elapsed_us  = s_tdata[47:16];

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.setup_up_us      <= 20'd49747;
            cfg_reg.setup_down_us    <= 20'd49746;
            cfg_reg.settle_up_us     <= 20'd339;
            cfg_reg.settle_down_us   <= 20'd327;
            cfg_reg.calib_latency_us <= 24'd3732491;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_SETUP_UP:    cfg_reg.setup_up_us      <= cfg_wdata[19:0];
                REG_SETUP_DOWN:  cfg_reg.setup_down_us    <= cfg_wdata[19:0];
                REG_SETTLE_UP:   cfg_reg.settle_up_us     <= cfg_wdata[19:0];
                REG_SETTLE_DOWN: cfg_reg.settle_down_us   <= cfg_wdata[19:0];
                REG_CALIB:       cfg_reg.calib_latency_us <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // ramp front end: early results and the scaled table position
    spre_ramp u_ramp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s_tvalid),
        .in_beat   (in_beat),
        .cfg       (cfg_reg),
        .out_valid (r_valid),
        .q         (r_q),
        .side      (r_side)
    );

    // position / (23 * rate): integer table value and remainder
    spre_div u_div_pos (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (r_valid),
        .dvd       (r_q),
        .dsr       (DIV_DW'(r_side.den)),
        .in_side   (r_side),
        .out_valid (d1_valid),
        .quo       (d1_quo),
        .rem       (d1_rem),
        .out_side  (d1_side)
    );

    spre_interp u_interp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (d1_valid),
        .quo       (d1_quo),
        .rem       (d1_rem),
        .in_side   (d1_side),
        .out_valid (i_valid),
        .num       (i_num),
        .gap       (i_gap),
        .out_side  (i_side)
    );

    // 256 * offset / segment length: fraction of a degree
    spre_div u_div_frac (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (i_valid),
        .dvd       (i_num),
        .dsr       (i_gap),
        .in_side   (i_side),
        .out_valid (d2_valid),
        .quo       (d2_quo),
        .rem       (d2_rem),
        .out_side  (d2_side)
    );

    // final result; the very end of the table is the top angle exactly
    always_comb
    begin
        out_next = d2_side.res;
        if (d2_side.moving)
        begin
            out_next.known = 1'b1;
            out_next.phase = PH_MOVING;
            out_next.q8    = d2_side.full ? FULL_Q8
                                          : ({d2_side.idx, 8'b0} + Q8_W'(d2_quo[7:0]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= d2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_reg.phase, out_reg.q8, out_reg.known};

    a_unknown_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.known |-> out_reg.q8 == '0 && out_reg.phase == PH_UNKNOWN)
        else $error("unknown result with nonzero angle or wrong phase");

    a_known_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.known |-> out_reg.q8 <= FULL_Q8 && out_reg.phase != PH_UNKNOWN)
        else $error("known result out of range");

    a_arrived_whole: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.known && out_reg.phase == PH_ARRIVED |-> out_reg.q8[7:0] == 8'd0)
        else $error("arrived result not a whole degree");

endmodule

@@ test/stepper_ramp_position_estimator_tb.sv @@
`timescale 1ns / 100ps

module stepper_ramp_position_estimator_tb;

    import spre_pkg::*;

    localparam int  LIMIT_CYCLES = 400000;
    // pipeline depth plus margin, used for the pause before config writes and at the end
    localparam int  DRAIN_CYCLES = 60;

    typedef struct {
        bit             known;
        bit [Q8_W-1:0]  q8;
        bit [PH_W-1:0]  phase;
    } angle_est_t;

    // steps spent in each rate level while accelerating; the top level takes the rest
    localparam longint LEVEL_STEPS [RATE_LEVELS] =
        '{400, 300, 200, 200, 200, 200, 200, 64'h10000000};

    // Tilt estimate predictor plus the queue of pending estimates.
    class tilt_scoreboard;
        longint     setup_up, setup_down, settle_up, settle_down, calib;
        angle_est_t pending[$];
        int         mismatches;
        int         beats_in;
        int         beats_out;

        function void set_reg(logic [CFG_AW-1:0] idx, longint val);
            case (idx)
                REG_SETUP_UP:    setup_up    = val & 20'hFFFFF;
                REG_SETUP_DOWN:  setup_down  = val & 20'hFFFFF;
                REG_SETTLE_UP:   settle_up   = val & 20'hFFFFF;
                REG_SETTLE_DOWN: settle_down = val & 20'hFFFFF;
                REG_CALIB:       calib       = val & 24'hFFFFFF;
                default: ;
            endcase
        endfunction

        function longint rate(int lvl);
            return longint'(RATE_US[lvl]);
        endfunction

        function longint tab(int a);
            return longint'(ANG_TAB[a]);
        endfunction

        // time to cover n steps on the symmetric ramp
        function longint ramp_duration(longint n);
            longint t;
            int     lvl;
            t = 0;
            for (lvl = 0; lvl < RATE_LEVELS - 1; lvl++)
            begin
                if (n < 2 * LEVEL_STEPS[lvl])
                    break;
                t += 2 * LEVEL_STEPS[lvl] * rate(lvl);
                n -= 2 * LEVEL_STEPS[lvl];
            end
            return t + n * rate(lvl);
        endfunction

        // steps covered after t us, as num/den
        function void steps_reached(longint t, longint total, output longint num,
                                    output longint den);
            longint rest, done, ns;
            int     lvl, top, dir, it;
            rest = total;
            done = 0;
            dir  = 1;
            for (lvl = 0; lvl < RATE_LEVELS - 1; lvl++)
            begin
                if (rest < 2 * LEVEL_STEPS[lvl])
                    break;
                rest -= 2 * LEVEL_STEPS[lvl];
            end
            top = lvl;
            lvl = 0;
            for (it = 0; it < 2 * RATE_LEVELS + 1; it++)
            begin
                if (lvl == top)
                begin
                    ns  = rest;
                    dir = -1;
                end
                else
                    ns = LEVEL_STEPS[lvl];
                if (t <= ns * rate(lvl))
                begin
                    num = done * rate(lvl) + t;
                    den = rate(lvl);
                    return;
                end
                t    -= ns * rate(lvl);
                done += ns;
                lvl  += dir;
                if (lvl < 0)
                    break;
            end
            num = total;
            den = 1;
        endfunction

        // table position q/den back to Q8 degrees by interpolation
        function longint position_to_q8(longint q, longint den);
            int     a;
            longint gap;
            a = 0;
            if (q <= tab(0) * den)
                return 0;
            if (q >= tab(MAX_ANGLE) * den)
                return MAX_ANGLE * 256;
            while (a < MAX_ANGLE - 1 && tab(a + 1) * den <= q)
                a++;
            gap = (tab(a + 1) - tab(a)) * den;
            if (gap <= 0)
                return a * 256;
            return a * 256 + ((q - tab(a) * den) * 256) / gap;
        endfunction

        function void push(bit known, longint q8, bit [PH_W-1:0] ph);
            angle_est_t r;
            r.known = known;
            r.q8    = known ? q8[Q8_W-1:0] : '0;
            r.phase = ph;
            pending.push_back(r);
        endfunction

        function void note_query(bit sk_in, int s, bit dk_in, int d, bit [31:0] e);
            bit     sk, dk;
            longint el, span, lim, setup, total, transit, m, den, q, diff;
            beats_in++;
            sk   = sk_in && s <= MAX_ANGLE;
            dk   = dk_in && d <= MAX_ANGLE;
            el   = longint'($signed(e));
            span = TAB_TO_STEPS * (tab(MAX_ANGLE) - tab(0));
            if (sk)
                lim = ramp_duration(span) + setup_down + settle_down;
            else
                lim = span * rate(RATE_LEVELS - 1) + calib;
            if (el >= lim)
            begin
                if (dk)
                    push(1, d * 256, PH_ARRIVED);
                else
                    push(0, 0, PH_UNKNOWN);
                return;
            end
            if (!sk || !dk || el < 0)
            begin
                push(0, 0, PH_UNKNOWN);
                return;
            end
            setup   = (s < d) ? setup_up : setup_down;
            diff    = tab(d) - tab(s);
            total   = TAB_TO_STEPS * (diff < 0 ? -diff : diff);
            transit = (s == d) ? 0 : ramp_duration(total);
            if (el >= transit + setup)
                push(1, d * 256, PH_ARRIVED);
            else if (el <= setup)
                push(1, s * 256, PH_SETUP);
            else
            begin
                steps_reached(el - setup, total, m, den);
                q = TAB_TO_STEPS * tab(s) * den + (d > s ? m : -m);
                push(1, position_to_q8(q, TAB_TO_STEPS * den), PH_MOVING);
            end
        endfunction

        function void check_result(bit [23:0] data);
            angle_est_t exp_r;
            beats_out++;
            if (pending.size() == 0)
            begin
                $error("result beat %h with no estimate pending", data);
                mismatches++;
                return;
            end
            exp_r = pending.pop_front();
            if (data[0] !== exp_r.known)
            begin
                $error("angle_known: expected %0d, got %0d", exp_r.known, data[0]);
                mismatches++;
            end
            if (data[15:1] !== exp_r.q8)
            begin
                $error("angle_q8: expected %0d, got %0d", exp_r.q8, data[15:1]);
                mismatches++;
            end
            if (data[17:16] !== exp_r.phase)
            begin
                $error("phase: expected %0d, got %0d", exp_r.phase, data[17:16]);
                mismatches++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [47:0]         s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [23:0]         m_tdata;
    logic                cfg_we;
    logic [CFG_AW-1:0]   cfg_addr;
    logic [CFG_DW-1:0]   cfg_wdata;

    tilt_scoreboard sb;
    bit             steady;      // set for the closing stretch: no idling on either side
    int             settings;
    longint         cycles;

    stepper_ramp_position_estimator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side: bursty backpressure, changed on the falling edge
    initial
    begin : ready_gen
        int hold;
        hold     = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (steady)
                m_tready = 1'b1;
            else if (hold > 0)
            begin
                m_tready = 1'b0;
                hold--;
            end
            else
            begin
                m_tready = 1'b1;
                if ($urandom_range(0, 7) == 0)
                    hold = $urandom_range(1, 9);
            end
        end
    end

    // Result beats are checked at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // One query beat, called at a falling edge; held until accepted, so beats can
    // follow back to back, with an optional idle burst afterwards
    task automatic send_query(bit sk, int s, bit dk, int d, bit [31:0] e);
        s_tdata  = {e, d[6:0], dk, s[6:0], sk};
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_query(sk, s, dk, d, e);
        @(negedge clk);
        s_tvalid = 1'b0;
        if (!steady && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 9)) @(negedge clk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_AW-1:0] idx, longint val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val[CFG_DW-1:0];
        @(negedge clk);
        cfg_we    = 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic load_regs(longint su, longint sd, longint tu, longint td, longint cl);
        drain();
        write_reg(REG_SETUP_UP, su);
        write_reg(REG_SETUP_DOWN, sd);
        write_reg(REG_SETTLE_UP, tu);
        write_reg(REG_SETTLE_DOWN, td);
        write_reg(REG_CALIB, cl);
        settings++;
    endtask

    function automatic int pick_angle();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(MAX_ANGLE + 1, 127);
        return $urandom_range(0, MAX_ANGLE);
    endfunction

    // Mostly valid queries with times spread over setup, motion and the limits
    task automatic random_queries(int n);
        bit          sk, dk;
        int          s, d;
        bit [31:0]   e;
        repeat (n)
        begin
            sk = ($urandom_range(0, 9) != 0);
            dk = ($urandom_range(0, 9) != 0);
            s  = pick_angle();
            d  = ($urandom_range(0, 9) == 0) ? s : pick_angle();
            case ($urandom_range(0, 9))
                0:       e = $urandom;
                1:       e = -$urandom_range(1, 100000);
                2, 3:    e = $urandom_range(0, 300000);
                4, 5:    e = $urandom_range(0, 1500000);
                6, 7, 8: e = $urandom_range(0, 12000000);
                default: e = $urandom_range(11000000, 24000000);
            endcase
            send_query(sk, s, dk, d, e);
        end
    endtask

    initial
    begin
        sb        = new();
        sb.set_reg(REG_SETUP_UP, 49747);
        sb.set_reg(REG_SETUP_DOWN, 49746);
        sb.set_reg(REG_SETTLE_UP, 339);
        sb.set_reg(REG_SETTLE_DOWN, 327);
        sb.set_reg(REG_CALIB, 3732491);
        steady    = 1'b0;
        settings  = 1;
        cycles    = 0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, unknowns, setup edge, limits, motion both ways
        send_query(1, 0, 1, 90, 0);
        send_query(1, 0, 1, 90, 49747);
        send_query(1, 0, 1, 90, 49748);
        send_query(1, 0, 1, 90, 1000000);
        send_query(1, 0, 1, 90, 6000000);
        send_query(1, 90, 1, 0, 3000000);
        send_query(1, 45, 1, 45, 49746);
        send_query(1, 45, 1, 45, 49747);
        send_query(0, 10, 1, 20, 100000);
        send_query(1, 10, 0, 20, 100000);
        send_query(1, 127, 1, 20, 100000);
        send_query(1, 20, 1, 127, 100000);
        send_query(1, 20, 1, 30, 32'hFFFF_FFFF);
        send_query(1, 20, 1, 30, 32'h8000_0000);
        send_query(1, 20, 1, 30, 32'h7FFF_FFFF);
        send_query(1, 20, 1, 30, 11628654);      // one below the known-start limit
        send_query(1, 20, 0, 30, 11628655);      // at the limit, target unknown
        send_query(0, 20, 1, 30, 13370272);      // one below the calibration limit
        send_query(0, 20, 1, 30, 13370273);
        send_query(1, 89, 1, 90, 50000);
        send_query(1, 1, 1, 0, 55000);
        random_queries(80);

        load_regs(0, 0, 0, 0, 0);
        random_queries(90);
        // let the pipeline run dry mid-phase
        while (sb.pending.size() != 0)
            @(posedge clk);
        @(negedge clk);
        random_queries(10);

        load_regs(1000000, 1000000, 1000000, 1000000, 10000000);
        random_queries(100);

        load_regs($urandom_range(0, 1000000), $urandom_range(0, 1000000),
                  $urandom_range(0, 1000000), $urandom_range(0, 1000000),
                  $urandom_range(0, 10000000));
        random_queries(100);

        load_regs(49747, 49746, 339, 327, 3732491);
        steady = 1'b1;
        random_queries(100);

        drain();
        $display("Run covered %0d query beats and %0d result beats over %0d register settings",
                 sb.beats_in, sb.beats_out, settings);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/spre_pkg.sv
rtl/core/spre_div.sv
rtl/core/spre_ramp.sv
rtl/core/spre_interp.sv
rtl/core/stepper_ramp_position_estimator.sv
test/stepper_ramp_position_estimator_tb.sv
